/* design/tglf_pkg.sv */
// Package: shared types, codes and tables for the touch-gated line-follow control block.
package tglf_pkg;

    typedef enum logic [1:0] {
        MODE_TOUCH  = 2'd0,
        MODE_SECOND = 2'd1,
        MODE_SYNC   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    localparam logic CFG_BLACK_THRESHOLD = 1'b0;
    localparam logic CFG_WHITE_THRESHOLD = 1'b1;

    localparam logic [4:0] PHASE_SUM_START = 5'd10;
    localparam logic [4:0] PHASE_SUM_END   = 5'd18;

    localparam logic [9:0] BLACK_RESET = 10'd700;
    localparam logic [9:0] WHITE_RESET = 10'd300;

    localparam logic [1:0] DRIVE_STOP = 2'd0;
    localparam logic [1:0] DRIVE_HALF = 2'd1;
    localparam logic [1:0] DRIVE_FULL = 2'd2;

    localparam logic [2:0] LED_LEFT   = 3'b001;
    localparam logic [2:0] LED_CENTRE = 3'b010;
    localparam logic [2:0] LED_RIGHT  = 3'b100;

    typedef struct packed {
        logic [1:0] left_drive;
        logic [1:0] right_drive;
        logic [2:0] led_bits;
        logic       weak_touch;
        logic       strong_touch;
        logic [2:0] fault_pattern;
        logic [2:0] line_pattern;
    } t_result;

    typedef struct packed {
        logic [1:0] left;
        logic [1:0] right;
        logic [2:0] leds;
    } t_steer;

    function automatic t_steer steer_lookup(input logic [2:0] pattern);
        t_steer s;
        case (pattern)
            3'd0: s = '{DRIVE_STOP, DRIVE_STOP, 3'b000};
            3'd1: s = '{DRIVE_STOP, DRIVE_FULL, LED_LEFT};
            3'd2: s = '{DRIVE_FULL, DRIVE_FULL, LED_CENTRE};
            3'd3: s = '{DRIVE_HALF, DRIVE_FULL, LED_LEFT | LED_CENTRE};
            3'd4: s = '{DRIVE_FULL, DRIVE_STOP, LED_RIGHT};
            3'd5: s = '{DRIVE_FULL, DRIVE_FULL, LED_CENTRE};
            3'd6: s = '{DRIVE_FULL, DRIVE_HALF, LED_RIGHT | LED_CENTRE};
            default: s = '{DRIVE_FULL, DRIVE_FULL, LED_CENTRE};
        endcase
        return s;
    endfunction

endpackage

/* design/tglf_in_if.sv */
// Interface: input event channel with valid/ready handshake.
interface tglf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] touch_count;
    logic [2:0]  random_bits;
    logic [9:0]  sensor_left;
    logic [9:0]  sensor_mid;
    logic [9:0]  sensor_right;

    modport source (
        output valid, mode, touch_count, random_bits, sensor_left, sensor_mid, sensor_right,
        input  ready
    );
    modport sink (
        input  valid, mode, touch_count, random_bits, sensor_left, sensor_mid, sensor_right,
        output ready
    );
endinterface

/* design/tglf_out_if.sv */
// Interface: result channel with valid/ready handshake.
interface tglf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] left_drive;
    logic [1:0] right_drive;
    logic [2:0] led_bits;
    logic       weak_touch;
    logic       strong_touch;
    logic [2:0] fault_pattern;
    logic [2:0] line_pattern;

    modport source (
        output valid, left_drive, right_drive, led_bits, weak_touch, strong_touch,
               fault_pattern, line_pattern,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, led_bits, weak_touch, strong_touch,
               fault_pattern, line_pattern,
        output ready
    );
endinterface

/* design/touch_gated_line_follow_control_core.sv */
// Top level: touch-gated line-follow controller with two-entry result buffer.
// Throughput: one transaction per cycle while the output buffer has room;
// each result is registered there; state updates in one combinational pass.
// A two-entry output buffer keeps input ready while one result waits.
// Reset (synchronous, active low) clears all control state and loads
// threshold defaults of 700 and 300; no clearing pass is needed.
module touch_gated_line_follow_control_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [9:0]  i_cfg_data,
    tglf_in_if.sink     i_in,
    tglf_out_if.source  o_out
);

    logic [9:0]  r_black_threshold;
    logic [9:0]  r_white_threshold;
    logic [4:0]  r_phase_count, n_phase_count;
    logic [15:0] r_touch_sum, n_touch_sum;
    logic [15:0] r_strong_limit, n_strong_limit;
    logic [15:0] r_weak_limit, n_weak_limit;
    logic [1:0]  r_touch_bits, n_touch_bits;
    logic [2:0]  r_fault_mask, n_fault_mask;
    logic [2:0]  r_pattern_bits, n_pattern_bits;
    logic [3:0]  r_drive_levels, n_drive_levels;
    logic [2:0]  r_indicator_bits, n_indicator_bits;

    tglf_pkg::t_result r_head, r_tail, n_result;
    logic [1:0]        r_fill, n_fill;

    tglf_pkg::t_mode   w_mode;
    tglf_pkg::t_steer  w_steer;
    logic              w_push, w_pop;
    logic [4:0]        w_phase_a, w_phase_b;
    logic [15:0]       w_sum;
    logic [2:0]        w_shift;
    logic [2:0]        w_pat;
    logic [9:0]        w_sensor [3];

    assign w_mode      = tglf_pkg::t_mode'(i_in.mode);
    assign i_in.ready  = (r_fill != 2'd2);
    assign w_push      = i_in.valid && i_in.ready;
    assign w_pop       = o_out.valid && o_out.ready;
    assign w_sensor[0] = i_in.sensor_left;
    assign w_sensor[1] = i_in.sensor_mid;
    assign w_sensor[2] = i_in.sensor_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_threshold <= tglf_pkg::BLACK_RESET;
            r_white_threshold <= tglf_pkg::WHITE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tglf_pkg::CFG_BLACK_THRESHOLD: r_black_threshold <= i_cfg_data;
                tglf_pkg::CFG_WHITE_THRESHOLD: r_white_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase_count    = r_phase_count;
        n_touch_sum      = r_touch_sum;
        n_strong_limit   = r_strong_limit;
        n_weak_limit     = r_weak_limit;
        n_touch_bits     = r_touch_bits;
        n_fault_mask     = r_fault_mask;
        n_pattern_bits   = r_pattern_bits;
        n_drive_levels   = r_drive_levels;
        n_indicator_bits = r_indicator_bits;
        w_phase_a        = r_phase_count;
        w_phase_b        = r_phase_count;
        w_sum            = r_touch_sum;
        w_shift          = {r_fault_mask[1:0], 1'b0};
        w_pat            = r_pattern_bits;
        w_steer          = tglf_pkg::steer_lookup(r_pattern_bits);

        case (w_mode)
            tglf_pkg::MODE_TOUCH: begin
                if (r_phase_count < tglf_pkg::PHASE_SUM_START) begin
                    w_phase_a = r_phase_count + 5'd1;
                end
                w_phase_b = w_phase_a;
                if (w_phase_a >= tglf_pkg::PHASE_SUM_START
                        && w_phase_a < tglf_pkg::PHASE_SUM_END) begin
                    w_phase_b = w_phase_a + 5'd1;
                    w_sum     = r_touch_sum + {3'b000, i_in.touch_count[15:3]};
                end
                n_touch_sum   = w_sum;
                n_phase_count = w_phase_b;
                if (w_phase_b == tglf_pkg::PHASE_SUM_END) begin
                    n_strong_limit = w_sum - {2'b00, w_sum[15:2]};
                    n_weak_limit   = w_sum - {3'b000, w_sum[15:3]};
                    n_phase_count  = w_phase_b + 5'd1;
                end
                if (n_phase_count > tglf_pkg::PHASE_SUM_END) begin
                    n_touch_bits = {i_in.touch_count <= n_strong_limit,
                                    i_in.touch_count <= n_weak_limit};
                end
            end
            tglf_pkg::MODE_SECOND: begin
                if (r_touch_bits[0]) begin
                    n_fault_mask = (w_shift == 3'd0) ? i_in.random_bits : w_shift;
                end else begin
                    n_fault_mask = 3'd0;
                end
            end
            tglf_pkg::MODE_SYNC: begin
                for (int i = 0; i < 3; i++) begin
                    if (w_sensor[i] > r_black_threshold) begin
                        w_pat[i] = 1'b1;
                    end
                    if (w_sensor[i] < r_white_threshold) begin
                        w_pat[i] = 1'b0;
                    end
                end
                n_pattern_bits   = w_pat ^ r_fault_mask;
                w_steer          = tglf_pkg::steer_lookup(n_pattern_bits);
                n_drive_levels   = {w_steer.right, w_steer.left};
                n_indicator_bits = w_steer.leds;
            end
            default: ;
        endcase

        n_result.left_drive    = n_drive_levels[1:0];
        n_result.right_drive   = n_drive_levels[3:2];
        n_result.led_bits      = n_indicator_bits;
        n_result.weak_touch    = n_touch_bits[0];
        n_result.strong_touch  = n_touch_bits[1];
        n_result.fault_pattern = n_fault_mask;
        n_result.line_pattern  = n_pattern_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_count    <= '0;
            r_touch_sum      <= '0;
            r_strong_limit   <= '0;
            r_weak_limit     <= '0;
            r_touch_bits     <= '0;
            r_fault_mask     <= '0;
            r_pattern_bits   <= '0;
            r_drive_levels   <= '0;
            r_indicator_bits <= '0;
        end else if (w_push) begin
            r_phase_count    <= n_phase_count;
            r_touch_sum      <= n_touch_sum;
            r_strong_limit   <= n_strong_limit;
            r_weak_limit     <= n_weak_limit;
            r_touch_bits     <= n_touch_bits;
            r_fault_mask     <= n_fault_mask;
            r_pattern_bits   <= n_pattern_bits;
            r_drive_levels   <= n_drive_levels;
            r_indicator_bits <= n_indicator_bits;
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && (r_fill == 2'd0 || (r_fill == 2'd1 && w_pop))) begin
            r_head <= n_result;
        end else if (w_pop) begin
            r_head <= r_tail;
        end
        if (w_push && r_fill != 2'd0 && !(r_fill == 2'd1 && w_pop)) begin
            r_tail <= n_result;
        end
    end

    assign o_out.valid         = (r_fill != 2'd0);
    assign o_out.left_drive    = r_head.left_drive;
    assign o_out.right_drive   = r_head.right_drive;
    assign o_out.led_bits      = r_head.led_bits;
    assign o_out.weak_touch    = r_head.weak_touch;
    assign o_out.strong_touch  = r_head.strong_touch;
    assign o_out.fault_pattern = r_head.fault_pattern;
    assign o_out.line_pattern  = r_head.line_pattern;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench: directed and random event traffic for the line-follow controller, checked per transaction.
module tb_top;

    typedef struct {
        tglf_pkg::t_mode mode;
        logic [15:0]     count;
        logic [2:0]      rnd;
        logic [9:0]      left;
        logic [9:0]      mid;
        logic [9:0]      right;
    } t_tick;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [9:0] i_cfg_data;

    tglf_in_if  ev_ch();
    tglf_out_if st_ch();

    touch_gated_line_follow_control_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (ev_ch),
        .o_out      (st_ch)
    );

    logic [9:0]  black_lvl;
    logic [9:0]  white_lvl;
    logic [4:0]  cal_phase;
    logic [15:0] pad_sum;
    logic [15:0] strong_lim;
    logic [15:0] weak_lim;
    logic        weak_flag;
    logic        strong_flag;
    logic [2:0]  fault_mask;
    logic [2:0]  line_bits;
    logic [1:0]  left_lvl;
    logic [1:0]  right_lvl;
    logic [2:0]  led_lvl;

    t_tick             tick_backlog[$];
    tglf_pkg::t_result status_due[$];
    t_tick             seen_tick;
    t_tick             next_tick;

    int ticks_posted = 0;
    int reports_seen = 0;
    int mismatches   = 0;
    int in_gap_max   = 0;
    int out_gap_max  = 0;
    int choke_req    = 0;
    int choke_left   = 0;
    int ev_idle      = 0;
    int st_idle      = 0;
    bit ev_took      = 1'b0;
    bit st_took      = 1'b0;

    int black_set[7] = '{600, 0, 1023, 0, 1023, 200, 700};
    int white_set[7] = '{400, 0, 1023, 1023, 0, 850, 300};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic advance_controller(input t_tick t);
        tglf_pkg::t_result r;
        logic [9:0]        samples [3];
        int                i;
        samples[0] = t.left;
        samples[1] = t.mid;
        samples[2] = t.right;
        case (t.mode)
            tglf_pkg::MODE_TOUCH: begin
                if (cal_phase < tglf_pkg::PHASE_SUM_START)
                    cal_phase = cal_phase + 5'd1;
                if (cal_phase >= tglf_pkg::PHASE_SUM_START
                        && cal_phase < tglf_pkg::PHASE_SUM_END) begin
                    cal_phase = cal_phase + 5'd1;
                    pad_sum = pad_sum + {3'b000, t.count[15:3]};
                end
                if (cal_phase == tglf_pkg::PHASE_SUM_END) begin
                    strong_lim = pad_sum - {2'b00, pad_sum[15:2]};
                    weak_lim = pad_sum - {3'b000, pad_sum[15:3]};
                    cal_phase = cal_phase + 5'd1;
                end
                if (cal_phase > tglf_pkg::PHASE_SUM_END) begin
                    weak_flag = (t.count <= weak_lim);
                    strong_flag = (t.count <= strong_lim);
                end
            end
            tglf_pkg::MODE_SECOND: begin
                if (weak_flag) begin
                    fault_mask = {fault_mask[1:0], 1'b0};
                    if (fault_mask == 3'd0)
                        fault_mask = t.rnd;
                end else begin
                    fault_mask = 3'd0;
                end
            end
            tglf_pkg::MODE_SYNC: begin
                for (i = 0; i < 3; i++) begin
                    if (samples[i] > black_lvl)
                        line_bits[i] = 1'b1;
                    if (samples[i] < white_lvl)
                        line_bits[i] = 1'b0;
                end
                line_bits = line_bits ^ fault_mask;
                case (line_bits)
                    3'd0: begin
                        left_lvl = tglf_pkg::DRIVE_STOP;
                        right_lvl = tglf_pkg::DRIVE_STOP;
                        led_lvl = '0;
                    end
                    3'd1: begin
                        left_lvl = tglf_pkg::DRIVE_STOP;
                        right_lvl = tglf_pkg::DRIVE_FULL;
                        led_lvl = tglf_pkg::LED_LEFT;
                    end
                    3'd3: begin
                        left_lvl = tglf_pkg::DRIVE_HALF;
                        right_lvl = tglf_pkg::DRIVE_FULL;
                        led_lvl = tglf_pkg::LED_LEFT | tglf_pkg::LED_CENTRE;
                    end
                    3'd4: begin
                        left_lvl = tglf_pkg::DRIVE_FULL;
                        right_lvl = tglf_pkg::DRIVE_STOP;
                        led_lvl = tglf_pkg::LED_RIGHT;
                    end
                    3'd6: begin
                        left_lvl = tglf_pkg::DRIVE_FULL;
                        right_lvl = tglf_pkg::DRIVE_HALF;
                        led_lvl = tglf_pkg::LED_RIGHT | tglf_pkg::LED_CENTRE;
                    end
                    default: begin
                        left_lvl = tglf_pkg::DRIVE_FULL;
                        right_lvl = tglf_pkg::DRIVE_FULL;
                        led_lvl = tglf_pkg::LED_CENTRE;
                    end
                endcase
            end
            default: ;
        endcase
        r.left_drive    = left_lvl;
        r.right_drive   = right_lvl;
        r.led_bits      = led_lvl;
        r.weak_touch    = weak_flag;
        r.strong_touch  = strong_flag;
        r.fault_pattern = fault_mask;
        r.line_pattern  = line_bits;
        status_due.push_back(r);
    endtask

    task automatic check_status();
        tglf_pkg::t_result want;
        if (status_due.size() == 0) begin
            note_mismatch("status transaction with nothing expected");
            return;
        end
        want = status_due.pop_front();
        check_field("left_drive", 16'(st_ch.left_drive), 16'(want.left_drive));
        check_field("right_drive", 16'(st_ch.right_drive), 16'(want.right_drive));
        check_field("led_bits", 16'(st_ch.led_bits), 16'(want.led_bits));
        check_field("weak_touch", 16'(st_ch.weak_touch), 16'(want.weak_touch));
        check_field("strong_touch", 16'(st_ch.strong_touch), 16'(want.strong_touch));
        check_field("fault_pattern", 16'(st_ch.fault_pattern), 16'(want.fault_pattern));
        check_field("line_pattern", 16'(st_ch.line_pattern), 16'(want.line_pattern));
    endtask

    always @(posedge i_clk) begin
        ev_took = 1'b0;
        st_took = 1'b0;
        if (i_rst_n) begin
            if (ev_ch.valid && ev_ch.ready) begin
                ev_took = 1'b1;
                seen_tick.mode  = tglf_pkg::t_mode'(ev_ch.mode);
                seen_tick.count = ev_ch.touch_count;
                seen_tick.rnd   = ev_ch.random_bits;
                seen_tick.left  = ev_ch.sensor_left;
                seen_tick.mid   = ev_ch.sensor_mid;
                seen_tick.right = ev_ch.sensor_right;
                advance_controller(seen_tick);
            end
            if (st_ch.valid && st_ch.ready) begin
                st_took = 1'b1;
                reports_seen++;
                check_status();
            end
        end
    end

    always @(negedge i_clk) begin
        if (!ev_ch.valid || ev_took) begin
            if (ev_idle > 0) begin
                ev_ch.valid <= 1'b0;
                ev_idle--;
            end else if (tick_backlog.size() > 0) begin
                next_tick = tick_backlog.pop_front();
                ev_ch.valid        <= 1'b1;
                ev_ch.mode         <= next_tick.mode;
                ev_ch.touch_count  <= next_tick.count;
                ev_ch.random_bits  <= next_tick.rnd;
                ev_ch.sensor_left  <= next_tick.left;
                ev_ch.sensor_mid   <= next_tick.mid;
                ev_ch.sensor_right <= next_tick.right;
                ev_idle = $urandom_range(0, in_gap_max);
            end else begin
                ev_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (choke_req > 0) begin
            choke_left = choke_req;
            choke_req = 0;
        end
        if (st_took)
            st_idle = $urandom_range(0, out_gap_max);
        if (choke_left > 0) begin
            st_ch.ready <= 1'b0;
            choke_left--;
        end else if (st_idle > 0) begin
            st_ch.ready <= 1'b0;
            st_idle--;
        end else begin
            st_ch.ready <= 1'b1;
        end
    end

    function automatic t_tick make_tick(input tglf_pkg::t_mode m, input int count,
                                        input int rnd, input int l, input int c,
                                        input int r);
        t_tick t;
        t.mode  = m;
        t.count = 16'(count);
        t.rnd   = 3'(rnd);
        t.left  = 10'(l);
        t.mid   = 10'(c);
        t.right = 10'(r);
        return t;
    endfunction

    function automatic logic [9:0] sample_near(input int lvl);
        int v;
        int pick;
        v = $urandom_range(0, 4);
        pick = $urandom_range(0, 9);
        v = lvl + v - 2;
        if (pick >= 6)
            v = $urandom_range(0, 1023);
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return 10'(v);
    endfunction

    function automatic logic [15:0] count_near();
        int v;
        int pick;
        int d;
        pick = $urandom_range(0, 9);
        d = $urandom_range(0, 6);
        if (pick < 4)
            v = weak_lim + d - 3;
        else if (pick < 6)
            v = strong_lim + d - 3;
        else if (pick < 8)
            v = $urandom_range(0, strong_lim);
        else
            v = $urandom_range(0, 65535);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    task automatic post(input t_tick t);
        tick_backlog.push_back(t);
        ticks_posted++;
    endtask

    task automatic post_burst(output int made);
        t_tick t;
        int    kind;
        int    k;
        kind = $urandom_range(0, 19);
        if (kind < 6)
            made = $urandom_range(1, 3);
        else if (kind < 12)
            made = $urandom_range(1, 5);
        else if (kind < 19)
            made = $urandom_range(1, 4);
        else
            made = 1;
        for (k = 0; k < made; k++) begin
            t = make_tick(tglf_pkg::MODE_NONE, $urandom_range(0, 65535),
                          $urandom_range(0, 7), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(0, 1023));
            if (kind < 6) begin
                t.mode = tglf_pkg::MODE_TOUCH;
                t.count = count_near();
            end else if (kind < 12) begin
                t.mode = tglf_pkg::MODE_SECOND;
            end else if (kind < 19) begin
                t.mode = tglf_pkg::MODE_SYNC;
                t.left = sample_near($urandom_range(0, 1) ? black_lvl : white_lvl);
                t.mid = sample_near($urandom_range(0, 1) ? black_lvl : white_lvl);
                t.right = sample_near($urandom_range(0, 1) ? black_lvl : white_lvl);
            end
            post(t);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (reports_seen < ticks_posted);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_thresholds(input int black, input int white);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tglf_pkg::CFG_BLACK_THRESHOLD;
        i_cfg_data <= 10'(black);
        @(negedge i_clk);
        i_cfg_idx  <= tglf_pkg::CFG_WHITE_THRESHOLD;
        i_cfg_data <= 10'(white);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        black_lvl = 10'(black);
        white_lvl = 10'(white);
    endtask

    initial begin
        int ph;
        int n;
        int made;
        int k;
        int sum_counts[8];
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = tglf_pkg::CFG_BLACK_THRESHOLD;
        i_cfg_data         = '0;
        ev_ch.valid        = 1'b0;
        ev_ch.mode         = tglf_pkg::MODE_NONE;
        ev_ch.touch_count  = '0;
        ev_ch.random_bits  = '0;
        ev_ch.sensor_left  = '0;
        ev_ch.sensor_mid   = '0;
        ev_ch.sensor_right = '0;
        st_ch.ready        = 1'b0;
        black_lvl   = tglf_pkg::BLACK_RESET;
        white_lvl   = tglf_pkg::WHITE_RESET;
        cal_phase   = '0;
        pad_sum     = '0;
        strong_lim  = '0;
        weak_lim    = '0;
        weak_flag   = 1'b0;
        strong_flag = 1'b0;
        fault_mask  = '0;
        line_bits   = '0;
        left_lvl    = tglf_pkg::DRIVE_STOP;
        right_lvl   = tglf_pkg::DRIVE_STOP;
        led_lvl     = '0;
        sum_counts = '{65535, 0, 8000, 8000, 8000, 8000, 8007, 7999};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        in_gap_max = 2;
        out_gap_max = 2;
        post(make_tick(tglf_pkg::MODE_NONE, 65535, 7, 1023, 1023, 1023));
        post(make_tick(tglf_pkg::MODE_SYNC, 0, 0, 701, 700, 299));
        post(make_tick(tglf_pkg::MODE_SYNC, 0, 0, 300, 1023, 0));
        post(make_tick(tglf_pkg::MODE_SYNC, 65535, 7, 1023, 1023, 1023));
        post(make_tick(tglf_pkg::MODE_SECOND, 0, 5, 0, 0, 0));
        for (k = 0; k < 9; k++)
            post(make_tick(tglf_pkg::MODE_TOUCH, (k % 2 == 0) ? 0 : 65535, k % 8,
                           0, 0, 0));
        for (k = 0; k < 8; k++)
            post(make_tick(tglf_pkg::MODE_TOUCH, sum_counts[k], 0, 0, 0, 0));
        post(make_tick(tglf_pkg::MODE_TOUCH, 0, 0, 0, 0, 0));
        post(make_tick(tglf_pkg::MODE_SECOND, 0, 0, 0, 0, 0));
        post(make_tick(tglf_pkg::MODE_SECOND, 0, 1, 0, 0, 0));
        post(make_tick(tglf_pkg::MODE_SECOND, 0, 7, 0, 0, 0));
        post(make_tick(tglf_pkg::MODE_SYNC, 0, 0, 0, 0, 0));

        for (ph = 0; ph < 7; ph++) begin
            wait_drained();
            write_thresholds(black_set[ph], white_set[ph]);
            @(posedge i_clk);
            in_gap_max = (ph % 3 == 0) ? 0 : 4;
            out_gap_max = (ph % 2 == 1) ? 0 : 4;
            if (ph == 3)
                choke_req = 60;
            n = 0;
            while (n < 265) begin
                post_burst(made);
                n += made;
            end
        end

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (status_due.size() != 0)
            note_mismatch($sformatf("%0d status transactions never arrived",
                                    status_due.size()));
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* touch_gated_line_follow_control_core.f */
design/tglf_pkg.sv
design/tglf_in_if.sv
design/tglf_out_if.sv
design/touch_gated_line_follow_control_core.sv
tb/tb_top.sv
